>>> src/tep_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the track existence probability unit.
// No dependencies.
package tep_pkg;

  // Item kinds
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_INIT   = 2'd1;
  localparam logic [1:0] KIND_MEAS   = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TRUST      = 2'd0;
  localparam logic [1:0] CFG_TRUE_DET   = 2'd1;
  localparam logic [1:0] CFG_FALSE_DET  = 2'd2;
  localparam logic [1:0] CFG_HALF_LIFE  = 2'd3;

  localparam logic [15:0] TRUE_DET_RST  = 16'd58982;
  localparam logic [15:0] FALSE_DET_RST = 16'd13107;
  localparam logic [15:0] HALF_LIFE_RST = 16'd300;
  localparam logic [15:0] BASE_Q16      = 16'd58982;  // 0.9

  typedef logic [15:0][31:0] pow_tab_t;

  function automatic logic [63:0] tep_isqrt(input logic [63:0] x_in);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bt;
    x  = x_in;
    r  = 64'd0;
    bt = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + bt) begin
        x = x - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  // T[b] = 2^32 * 2^(-2^(b-16)), built by repeated integer square roots
  function automatic pow_tab_t tep_pow_tab();
    pow_tab_t    t;
    logic [63:0] v;
    v = tep_isqrt(64'h8000_0000_0000_0000);
    t[15] = v[31:0];
    for (int b = 15; b > 0; b--) begin
      v = tep_isqrt({t[b], 32'd0});
      t[b-1] = v[31:0];
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TAB = tep_pow_tab();

endpackage

>>> src/tep_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for items and results.
// No dependencies.
interface tep_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  channel;
  logic [31:0] stamp_ms;
  logic [15:0] detector_prob;
  modport source (output valid, kind, channel, stamp_ms, detector_prob, input ready);
  modport sink   (input valid, kind, channel, stamp_ms, detector_prob, output ready);
endinterface

interface tep_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] total_prob;
  logic [15:0] channel_prob;
  logic [15:0] misses_in_row;
  logic [15:0] hits_total;
  modport source (output valid, total_prob, channel_prob, misses_in_row, hits_total,
                  input ready);
  modport sink   (input valid, total_prob, channel_prob, misses_in_row, hits_total,
                  output ready);
endinterface

>>> src/tep_mul.sv
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// No dependencies.
module tep_mul #(
  parameter int WA = 33,
  parameter int WB = 33
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [WA-1:0]      a_i,
  input  logic [WB-1:0]      b_i,
  output logic               done_o,
  output logic [WA+WB-1:0]   prod_o
);
  localparam int CW = $clog2(WB + 1);

  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WA-1:0]    a_q;
  logic [WA+WB-1:0] acc_q;
  logic [WA:0]      sum;

  assign sum = {1'b0, acc_q[WA+WB-1:WB]} + (acc_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(WB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      a_q   <= a_i;
      acc_q <= {{WA{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[WB-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> src/tep_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle; dividend bits enter the
// partial remainder MSB first. No dependencies.
module tep_div #(
  parameter int RW = 33,
  parameter int DW = 48,
  parameter int SW = $clog2(DW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          go_i,
  input  logic [RW-1:0] rem_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [RW-1:0] den_i,
  input  logic [SW-1:0] steps_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o,
  output logic [RW-1:0] rem_o
);
  logic [SW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [RW-1:0] r_q;
  logic [DW-1:0] d_q;
  logic [DW-1:0] q_q;
  logic [RW-1:0] den_q;
  logic [RW:0]   r2;
  logic [RW:0]   rn;
  logic          ge;

  assign r2 = {r_q, d_q[DW-1]};
  assign ge = r2 >= {1'b0, den_q};
  assign rn = ge ? r2 - {1'b0, den_q} : r2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      r_q   <= rem_i;
      d_q   <= dvd_i;
      q_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      r_q <= rn[RW-1:0];
      d_q <= {d_q[DW-2:0], 1'b0};
      q_q <= {q_q[DW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
  assign rem_o  = r_q;

endmodule

>>> src/track_existence_probability_unit.sv
`timescale 1ns / 1ps
// Existence probability tracker for one object: per-channel and total
// probabilities in Q0.PROB_BITS. Depends on tep_pkg, tep_if, tep_mul, tep_div.
//
// One item is worked on at a time; the next one is taken while the last
// result still waits on the output register. Create and channel-init items
// go straight to the output stage. Measurement and tick items run a serial
// divide for dt / half-life, then a serial multiply for each set bit of the
// fractional exponent, then walk the channels one by one: a decayed channel
// costs one multiply, a Bayesian update two multiplies and, unless the
// result saturates, a divide. The total comes last in the same way (a
// measurement adds one multiply for the detector-weighted likelihood).
// Item time is set mostly by the single shared bit-serial multiplier.
module track_existence_probability_unit
  import tep_pkg::*;
#(
  parameter int CHANNELS  = 8,
  parameter int PROB_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  tep_in_if.sink      in_i,
  tep_out_if.source   out_o
);
  localparam int PB = PROB_BITS;
  localparam int RW = 2 * PB + 1;          // Bayes numerator/denominator width
  localparam int DW = 48;                  // dt << 16
  localparam int MW = 33;                  // multiplier operand width
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IW = $clog2(CHANNELS + 1);
  localparam int SL = (PB >= 16) ? PB - 16 : 0;
  localparam int SR = (PB < 16) ? 16 - PB : 0;
  localparam logic [40:0] HALF_L = (41'd1 << SL) >> 1;
  localparam logic [40:0] HALF_R = (41'd1 << SR) >> 1;

  localparam longint unsigned ONE_L = 64'd1 << PB;
  localparam logic [PB:0] P_ONE   = (PB+1)'(ONE_L);
  localparam logic [PB:0] P_MAX   = (PB+1)'((999 * ONE_L + 500) / 1000);
  localparam logic [PB:0] P_MIN   = (PB+1)'((ONE_L + 5) / 10);
  localparam logic [PB:0] P_FLOOR = (PB+1)'((ONE_L + 500) / 1000);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIVX   = 4'd1;
  localparam logic [3:0] S_FBIT   = 4'd2;
  localparam logic [3:0] S_FMUL   = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_CH     = 4'd5;
  localparam logic [3:0] S_DMUL   = 4'd6;
  localparam logic [3:0] S_BMUL1  = 4'd7;
  localparam logic [3:0] S_BMUL2  = 4'd8;
  localparam logic [3:0] S_BDIV   = 4'd9;
  localparam logic [3:0] S_WB     = 4'd10;
  localparam logic [3:0] S_TPMUL  = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  function automatic logic [PB:0] from16(input logic [15:0] v);
    logic [40:0] w;
    w = 41'(v);
    if (PB >= 16) w = w << SL;
    else          w = (w + HALF_R) >> SR;
    return w[PB:0];
  endfunction

  function automatic logic [15:0] to16(input logic [PB:0] v);
    logic [40:0] w;
    w = 41'(v);
    if (PB >= 16) w = (w + HALF_L) >> SL;
    else          w = w << SR;
    return (w > 41'd65535) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [PB-1:0] clamp_upd(input logic [PB:0] q);
    logic [PB:0] c;
    c = (q > P_MAX) ? P_MAX : ((q < P_MIN) ? P_MIN : q);
    return c[PB-1:0];
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // configuration
  logic        trust_q;
  logic [15:0] tdp_q, fdp_q, half_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trust_q <= 1'b0;
      tdp_q   <= TRUE_DET_RST;
      fdp_q   <= FALSE_DET_RST;
      half_q  <= HALF_LIFE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRUST:     trust_q <= cfg_data_i[0];
        CFG_TRUE_DET:  tdp_q   <= cfg_data_i;
        CFG_FALSE_DET: fdp_q   <= cfg_data_i;
        CFG_HALF_LIFE: half_q  <= cfg_data_i;
        default:       trust_q <= trust_q;
      endcase
    end
  end

  // control and item state
  logic [3:0]    state_q, state_d;
  logic [1:0]    kind_q, kind_d;
  logic [2:0]    ch_q, ch_d;
  logic [15:0]   det_q, det_d;
  logic [31:0]   last_q, last_d;
  logic [15:0]   mrun_q, mrun_d, mtot_q, mtot_d, hit_q, hit_d;
  logic [PB-1:0] total_q, total_d;
  logic [CHANNELS-1:0] vld_q, vld_d;
  logic          out_vld_q, out_vld_d;
  logic [15:0]   o_tot_q, o_tot_d, o_ch_q, o_ch_d, o_mr_q, o_mr_d, o_hit_q, o_hit_d;

  // datapath registers
  logic [32:0]   f_q, f_d;
  logic          nbig_q, nbig_d;
  logic [4:0]    n_q, n_d;
  logic [15:0]   fr_q, fr_d;
  logic [4:0]    bit_q, bit_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          tot_q, tot_d;
  logic [PB-1:0] p_q, p_d;
  logic [RW-1:0] num_q, num_d, den_q, den_d;
  logic [PB-1:0] res_q, res_d;
  logic [15:0]   chp_q, chp_d;

  // channel memory
  logic [PB-1:0] mem [CHANNELS];
  logic [PB-1:0] rd_q;
  logic          rd_vld_q;
  logic          mem_we;
  logic [CW-1:0] mem_wa;
  logic [PB-1:0] mem_wd;

  // shared units
  logic               mul_go, mul_done;
  logic [MW-1:0]      mul_a, mul_b;
  logic [2*MW-1:0]    mul_prod;
  logic               div_go, div_done;
  logic [RW-1:0]      div_rem, div_den, div_rem_o;
  logic [DW-1:0]      div_dvd, div_quo;
  logic [5:0]         div_steps;

  tep_mul #(.WA(MW), .WB(MW)) u_mul (
    .clk_i, .rst_ni, .go_i(mul_go), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  tep_div #(.RW(RW), .DW(DW), .SW(6)) u_div (
    .clk_i, .rst_ni, .go_i(div_go), .rem_i(div_rem), .dvd_i(div_dvd), .den_i(div_den),
    .steps_i(div_steps), .done_o(div_done), .quo_o(div_quo), .rem_o(div_rem_o)
  );

  // combinational helpers
  logic          acc;
  logic [6:0]    in_chx, chx;
  logic          in_ok, ch_ok, idx_hit;
  logic [31:0]   dt_raw, dt;
  logic [15:0]   hl;
  logic [PB:0]   fdp_p, tdp_p, init_v;
  logic [PB-1:0] p_rd;
  logic [6:0]    sh_amt;
  logic [66:0]   dsum, dshift;
  logic [PB-1:0] dec_v;
  logic [RW-1:0] den_sum;
  logic [PB:0]   bq;
  logic [15:0]   base, tp16;
  logic [32:0]   f_next;

  assign acc     = in_i.valid && in_i.ready;
  assign in_chx  = {4'b0, in_i.channel};
  assign in_ok   = in_chx < 7'(CHANNELS);
  assign chx     = {4'b0, ch_q};
  assign ch_ok   = chx < 7'(CHANNELS);
  assign idx_hit = ch_ok && (7'(idx_q) == chx);
  assign dt_raw  = in_i.stamp_ms - last_q;
  assign dt      = dt_raw[31] ? 32'd0 : dt_raw;   // negative delta counts as zero
  assign hl      = (half_q == 16'd0) ? 16'd1 : half_q;
  assign fdp_p   = from16(fdp_q);
  assign tdp_p   = from16(tdp_q);
  assign init_v  = from16(in_i.detector_prob);
  assign p_rd    = rd_vld_q ? rd_q : P_FLOOR[PB-1:0];

  // decay: round(p * F / 2^(32+n)), floored at 0.001
  assign sh_amt  = 7'd32 + {2'b0, n_q};
  assign dsum    = {1'b0, mul_prod} + ((67'd1 << sh_amt) >> 1);
  assign dshift  = dsum >> sh_amt;
  assign dec_v   = nbig_q ? P_FLOOR[PB-1:0]
                 : ((dshift[PB:0] < P_FLOOR) ? P_FLOOR[PB-1:0] : dshift[PB-1:0]);

  assign den_sum = num_q + mul_prod[RW-1:0];
  assign bq      = {1'b0, div_quo[PB-1:0]} + (({div_rem_o, 1'b0} >= {1'b0, den_q}) ? 1'b1 : 1'b0);
  assign base    = trust_q ? det_q : BASE_Q16;
  assign tp16    = 16'((mul_prod[31:0] + 32'd32768) >> 16);
  assign f_next  = 33'((mul_prod + 66'h8000_0000) >> 32);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    ch_d      = ch_q;
    det_d     = det_q;
    last_d    = last_q;
    mrun_d    = mrun_q;
    mtot_d    = mtot_q;
    hit_d     = hit_q;
    total_d   = total_q;
    vld_d     = vld_q;
    f_d       = f_q;
    nbig_d    = nbig_q;
    n_d       = n_q;
    fr_d      = fr_q;
    bit_d     = bit_q;
    idx_d     = idx_q;
    tot_d     = tot_q;
    p_d       = p_q;
    num_d     = num_q;
    den_d     = den_q;
    res_d     = res_q;
    chp_d     = chp_q;
    out_vld_d = out_vld_q;
    o_tot_d   = o_tot_q;
    o_ch_d    = o_ch_q;
    o_mr_d    = o_mr_q;
    o_hit_d   = o_hit_q;
    mul_go    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_go    = 1'b0;
    div_rem   = '0;
    div_dvd   = '0;
    div_den   = '0;
    div_steps = 6'(DW);
    mem_we    = 1'b0;
    mem_wa    = idx_q[CW-1:0];
    mem_wd    = res_q;

    if (out_vld_q && out_o.ready) out_vld_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          kind_d = in_i.kind;
          ch_d   = in_i.channel;
          det_d  = in_i.detector_prob;
          chp_d  = 16'd0;
          case (in_i.kind)
            KIND_CREATE: begin
              vld_d   = '0;
              total_d = P_FLOOR[PB-1:0];
              mrun_d  = 16'd0;
              mtot_d  = 16'd0;
              hit_d   = 16'd1;
              last_d  = in_i.stamp_ms;
              chp_d   = in_ok ? to16(P_FLOOR) : 16'd0;
              state_d = S_FIN;
            end
            KIND_INIT: begin
              if (in_ok) begin
                mem_we = 1'b1;
                mem_wa = in_chx[CW-1:0];
                mem_wd = P_MIN[PB-1:0];
                vld_d[in_chx[CW-1:0]] = 1'b1;
                chp_d  = to16(P_MIN);
              end
              total_d = clamp_upd(init_v);
              state_d = S_FIN;
            end
            KIND_MEAS: begin
              mrun_d  = 16'd0;
              hit_d   = sat_inc(hit_q);
              last_d  = in_i.stamp_ms;
              div_go  = 1'b1;
              div_dvd = {dt, 16'd0};
              div_den = RW'(hl);
              state_d = S_DIVX;
            end
            default: begin
              mrun_d  = sat_inc(mrun_q);
              mtot_d  = sat_inc(mtot_q);
              div_go  = 1'b1;
              div_dvd = {dt, 16'd0};
              div_den = RW'(hl);
              state_d = S_DIVX;
            end
          endcase
        end
      end

      S_DIVX: begin
        if (div_done) begin
          nbig_d  = |div_quo[47:21];
          n_d     = div_quo[20:16];
          fr_d    = div_quo[15:0];
          f_d     = 33'h1_0000_0000;
          bit_d   = 5'd0;
          state_d = S_FBIT;
        end
      end

      // fold 2^(-fr/2^16) one set bit at a time
      S_FBIT: begin
        if (bit_q == 5'd16) begin
          idx_d   = '0;
          tot_d   = 1'b0;
          state_d = S_RD;
        end else if (fr_q[bit_q[3:0]]) begin
          mul_go  = 1'b1;
          mul_a   = f_q;
          mul_b   = {1'b0, POW_TAB[bit_q[3:0]]};
          state_d = S_FMUL;
        end else begin
          bit_d = bit_q + 5'd1;
        end
      end

      S_FMUL: begin
        if (mul_done) begin
          f_d     = f_next;
          bit_d   = bit_q + 5'd1;
          state_d = S_FBIT;
        end
      end

      S_RD: begin
        if (idx_q == IW'(CHANNELS)) begin
          tot_d  = 1'b1;
          p_d    = total_q;
          mul_go = 1'b1;
          if (kind_q == KIND_MEAS) begin
            mul_a   = MW'(base);
            mul_b   = MW'(tdp_q);
            state_d = S_TPMUL;
          end else begin
            mul_a   = MW'(total_q);
            mul_b   = f_q;
            state_d = S_DMUL;
          end
        end else begin
          state_d = S_CH;       // memory read lands next cycle
        end
      end

      S_CH: begin
        p_d    = p_rd;
        mul_go = 1'b1;
        mul_a  = MW'(p_rd);
        if (kind_q == KIND_MEAS && idx_hit) begin
          mul_b   = MW'(tdp_p);
          state_d = S_BMUL1;
        end else begin
          mul_b   = f_q;
          state_d = S_DMUL;
        end
      end

      S_DMUL: begin
        if (mul_done) begin
          res_d   = dec_v;
          state_d = S_WB;
        end
      end

      S_TPMUL: begin
        if (mul_done) begin
          mul_go  = 1'b1;
          mul_a   = MW'(p_q);
          mul_b   = MW'(from16(tp16));
          state_d = S_BMUL1;
        end
      end

      S_BMUL1: begin
        if (mul_done) begin
          num_d   = mul_prod[RW-1:0];
          mul_go  = 1'b1;
          mul_a   = MW'(P_ONE - {1'b0, p_q});
          mul_b   = MW'(fdp_p);
          state_d = S_BMUL2;
        end
      end

      S_BMUL2: begin
        if (mul_done) begin
          den_d = den_sum;
          if (den_sum == '0) begin
            res_d   = P_MIN[PB-1:0];
            state_d = S_WB;
          end else if (num_q >= den_sum) begin
            res_d   = clamp_upd(P_ONE);
            state_d = S_WB;
          end else begin
            div_go    = 1'b1;
            div_rem   = num_q;
            div_den   = den_sum;
            div_steps = 6'(PB);
            state_d   = S_BDIV;
          end
        end
      end

      S_BDIV: begin
        if (div_done) begin
          res_d   = clamp_upd(bq);
          state_d = S_WB;
        end
      end

      S_WB: begin
        if (tot_q) begin
          total_d = res_q;
          state_d = S_FIN;
        end else begin
          mem_we = 1'b1;
          vld_d[idx_q[CW-1:0]] = 1'b1;
          if (idx_hit) chp_d = to16({1'b0, res_q});
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end

      S_FIN: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          o_tot_d   = to16({1'b0, total_q});
          o_ch_d    = chp_q;
          o_mr_d    = mrun_q;
          o_hit_d   = hit_q;
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      last_q    <= 32'd0;
      mrun_q    <= 16'd0;
      mtot_q    <= 16'd0;
      hit_q     <= 16'd1;
      total_q   <= P_FLOOR[PB-1:0];
      vld_q     <= '0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
      bit_q     <= '0;
      tot_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      mrun_q    <= mrun_d;
      mtot_q    <= mtot_d;
      hit_q     <= hit_d;
      total_q   <= total_d;
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
      bit_q     <= bit_d;
      tot_q     <= tot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    ch_q    <= ch_d;
    det_q   <= det_d;
    f_q     <= f_d;
    nbig_q  <= nbig_d;
    n_q     <= n_d;
    fr_q    <= fr_d;
    p_q     <= p_d;
    num_q   <= num_d;
    den_q   <= den_d;
    res_q   <= res_d;
    chp_q   <= chp_d;
    o_tot_q <= o_tot_d;
    o_ch_q  <= o_ch_d;
    o_mr_q  <= o_mr_d;
    o_hit_q <= o_hit_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q     <= mem[idx_q[CW-1:0]];
    rd_vld_q <= vld_q[idx_q[CW-1:0]];
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_vld_q;
  assign out_o.total_prob    = o_tot_q;
  assign out_o.channel_prob  = o_ch_q;
  assign out_o.misses_in_row = o_mr_q;
  assign out_o.hits_total    = o_hit_q;

endmodule
